@@ design/plc_pkg.sv @@
// Shared types and constants for the polyline arc-length core.
// Used by plc_front, plc_sqrt_cell and polyline_arc_length_core; no dependencies.
package plc_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int IN_FIELD_W      = 32;
    localparam int IN_DATA_W       = 64;
    localparam int LEN_W           = 48;
    localparam int OUT_DATA_W      = 48;

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    // Flags that travel with each point down the pipeline.
    typedef struct packed {
        logic first;   // No previous point: the chord is not added.
        logic last;    // Final point of the path.
    } t_side;

endpackage

@@ design/plc_front.sv @@
// Front end of the arc-length core: coordinate difference, squares and their sum.
// Depends on plc_pkg; feeds the square-root cell row in polyline_arc_length_core.
module plc_front
    import plc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic [IN_DATA_W-1:0]       i_data,
    input  logic                       i_last,
    output logic                       o_vld,
    output logic [2*COORD_WIDTH+1:0]   o_rad,
    output t_side                      o_side
);

    localparam int CW = COORD_WIDTH;
    localparam int RW = 2 * CW + 2;

    logic          r_have_prev;
    logic [CW-1:0] r_prev_x;
    logic [CW-1:0] r_prev_y;

    logic [CW-1:0] w_x;
    logic [CW-1:0] w_y;
    logic [CW:0]   w_dx;
    logic [CW:0]   w_dy;
    logic [CW:0]   w_ndx;
    logic [CW:0]   w_ndy;
    logic [CW-1:0] w_mx;
    logic [CW-1:0] w_my;
    logic          w_take;

    logic [2:0]      r_vld;
    t_side           r_side_a;
    t_side           r_side_b;
    t_side           r_side_c;
    logic [CW-1:0]   r_mx;
    logic [CW-1:0]   r_my;
    logic [2*CW-1:0] r_sx;
    logic [2*CW-1:0] r_sy;
    logic [RW-1:0]   r_rad;

    assign w_take = i_en && i_vld;
    assign w_x    = i_data[CW-1:0];
    assign w_y    = i_data[IN_FIELD_W+CW-1:IN_FIELD_W];

    // Sign-extended differences; the magnitude always fits in CW bits.
    assign w_dx  = {w_x[CW-1], w_x} - {r_prev_x[CW-1], r_prev_x};
    assign w_dy  = {w_y[CW-1], w_y} - {r_prev_y[CW-1], r_prev_y};
    assign w_ndx = -w_dx;
    assign w_ndy = -w_dy;
    assign w_mx  = w_dx[CW] ? w_ndx[CW-1:0] : w_dx[CW-1:0];
    assign w_my  = w_dy[CW] ? w_ndy[CW-1:0] : w_dy[CW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_vld       <= '0;
        end else begin
            if (w_take) begin
                if (i_last) begin
                    r_have_prev <= 1'b0;
                    r_prev_x    <= '0;
                    r_prev_y    <= '0;
                end else begin
                    r_have_prev <= 1'b1;
                    r_prev_x    <= w_x;
                    r_prev_y    <= w_y;
                end
            end
            if (i_en) begin
                r_vld <= {r_vld[1:0], i_vld};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mx           <= w_mx;
            r_my           <= w_my;
            r_side_a.first <= !r_have_prev;
            r_side_a.last  <= i_last;
            r_sx           <= r_mx * r_mx;
            r_sy           <= r_my * r_my;
            r_side_b       <= r_side_a;
            r_rad          <= RW'({1'b0, r_sx} + {1'b0, r_sy});
            r_side_c       <= r_side_b;
        end
    end

    assign o_vld  = r_vld[2];
    assign o_rad  = r_rad;
    assign o_side = r_side_c;

    a_last_clears_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && i_last |=> !r_have_prev)
        else $error("previous point survived the end of a path");

    a_first_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> r_side_a.first == !$past(r_have_prev))
        else $error("first-point flag does not follow the held point");

    a_prev_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && !i_last |=> r_have_prev && r_prev_x == $past(w_x))
        else $error("previous x not captured on a beat");

endmodule

@@ design/plc_sqrt_cell.sv @@
// One cell of the restoring square-root row: one radicand bit pair per cell.
// Depends on plc_pkg; chained COORD_WIDTH+1 times in polyline_arc_length_core.
module plc_sqrt_cell
    import plc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic [2*COORD_WIDTH+1:0]   i_rad,
    input  logic [COORD_WIDTH+3:0]     i_rem,
    input  logic [COORD_WIDTH:0]       i_root,
    input  t_side                      i_side,
    output logic                       o_vld,
    output logic [2*COORD_WIDTH+1:0]   o_rad,
    output logic [COORD_WIDTH+3:0]     o_rem,
    output logic [COORD_WIDTH:0]       o_root,
    output t_side                      o_side
);

    localparam int CW    = COORD_WIDTH;
    localparam int RW    = 2 * CW + 2;
    localparam int REM_W = CW + 4;

    logic [REM_W-1:0] w_rem_s;
    logic [REM_W-1:0] w_trial;
    logic             w_ge;

    logic             r_vld;
    logic [RW-1:0]    r_rad;
    logic [REM_W-1:0] r_rem;
    logic [CW:0]      r_root;
    t_side            r_side;

    // Bring down the next pair and try to subtract 4*root + 1.
    assign w_rem_s = {i_rem[REM_W-3:0], i_rad[RW-1 -: 2]};
    assign w_trial = REM_W'({i_root, 2'b01});
    assign w_ge    = w_rem_s >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= {i_rad[RW-3:0], 2'b00};
            r_rem  <= w_ge ? (w_rem_s - w_trial) : w_rem_s;
            r_root <= {i_root[CW-1:0], w_ge};
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_side = r_side;

endmodule

@@ design/polyline_arc_length_core.sv @@
// Top level of the polyline arc-length core: front end, square-root cell row, accumulator.
// Depends on plc_pkg, plc_front and plc_sqrt_cell.
//
// Usage: path points enter on the slave stream, one point per beat. i_s_tdata carries
// point_x in bits 31:0 and point_y in bits 63:32 (signed Q16.16); i_s_tlast marks the
// final point of a path. Each point produces exactly one beat on the master stream:
// o_m_tdata is the cumulative chord length (unsigned Q32.16, saturating at all ones)
// and o_m_tlast echoes the path end. The first point of a path reports zero.
// Pipeline: three front stages for difference, squares and sum, one square-root cell
// per result bit, and the output register. One point is accepted every cycle while
// the receiver does not stall; only the final add feeds back, and it completes within
// the accumulator stage.
// Reset (synchronous, active low) empties the pipeline, clears the held point and the
// running sum. When the receiver stalls, the whole pipeline holds and o_s_tready drops
// until the output register is taken.
module polyline_arc_length_core
    import plc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_DATA_W-1:0]   i_s_tdata,   // [31:0] point_x, [63:32] point_y
    input  logic                   i_s_tlast,   // last_point
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_DATA_W-1:0]  o_m_tdata,   // [47:0] arc_length
    output logic                   o_m_tlast    // path_end
);

    localparam int CW    = COORD_WIDTH;
    localparam int RW    = 2 * CW + 2;
    localparam int REM_W = CW + 4;
    localparam int NCELL = CW + 1;

    logic w_en;

    logic          w_vld  [0:NCELL];
    logic [RW-1:0] w_rad  [0:NCELL];
    logic [REM_W-1:0] w_rem [0:NCELL];
    logic [CW:0]   w_root [0:NCELL];
    t_side         w_side [0:NCELL];

    logic             r_out_valid;
    logic [LEN_W-1:0] r_out_data;
    logic             r_out_last;
    logic [LEN_W-1:0] r_acc;

    logic [LEN_W:0]   w_sum;
    logic [LEN_W-1:0] w_sat;
    logic [LEN_W-1:0] w_acc_next;
    logic             w_done;

    assign w_en       = !r_out_valid || i_m_tready;
    assign o_s_tready = w_en;

    plc_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_s_tvalid),
        .i_data  (i_s_tdata),
        .i_last  (i_s_tlast),
        .o_vld   (w_vld[0]),
        .o_rad   (w_rad[0]),
        .o_side  (w_side[0])
    );

    assign w_rem[0]  = '0;
    assign w_root[0] = '0;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        plc_sqrt_cell #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_vld[g]),
            .i_rad   (w_rad[g]),
            .i_rem   (w_rem[g]),
            .i_root  (w_root[g]),
            .i_side  (w_side[g]),
            .o_vld   (w_vld[g+1]),
            .o_rad   (w_rad[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_root  (w_root[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    assign w_done     = w_en && w_vld[NCELL];
    assign w_sum      = {1'b0, r_acc} + {1'b0, LEN_W'(w_root[NCELL])};
    assign w_sat      = w_sum[LEN_W] ? LEN_MAX : w_sum[LEN_W-1:0];
    assign w_acc_next = w_side[NCELL].first ? r_acc : w_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_acc       <= '0;
        end else begin
            if (w_en) begin
                r_out_valid <= w_vld[NCELL];
            end
            if (w_done) begin
                r_acc <= w_side[NCELL].last ? '0 : w_acc_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_data <= w_acc_next;
            r_out_last <= w_side[NCELL].last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done && w_side[NCELL].last |=> r_acc == '0)
        else $error("running sum not cleared at path end");

    a_first_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done && w_side[NCELL].first |=> r_out_data == '0)
        else $error("first point of a path reported a nonzero length");

    a_sum_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done && !w_side[NCELL].last |=> r_acc >= $past(r_acc))
        else $error("running sum decreased inside a path");

endmodule
